// ----- src/cmtp_pkg.sv -----
`default_nettype none

package cmtp_pkg;

    // Request types on the two streaming channels.
    typedef struct packed {
        logic [7:0] char_code;
        logic       block_start;
    } cmtp_in_t;

    typedef struct packed {
        logic [3:0]  voice;
        logic [31:0] start_time;
        logic [23:0] duration;
        logic [22:0] frequency_q8;
        logic        is_rest;
        logic [31:0] block_length;
        logic [2:0]  error_code;
    } cmtp_out_t;

    // Command handed from the parser front to the timing back end.
    typedef struct packed {
        logic        clear;
        logic        emit;
        logic [2:0]  error_code;
        logic [3:0]  voice;
        logic        rest;
        logic [22:0] freq;
        logic [2:0]  len_shift;
    } cmtp_cmd_t;

    // Queue status seen by the front.
    typedef struct packed {
        logic full;
        logic empty;
    } cmtp_q_status_t;

    localparam int unsigned QUEUE_DEPTH = 4;
    localparam int unsigned QPTR_W      = 2;
    localparam int unsigned QCNT_W      = 3;

    localparam logic [23:0] WHOLE_RESET = 24'd144000;

    // Error codes.
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_OCTAVE  = 3'd1;
    localparam logic [2:0] ERR_UNKNOWN = 3'd2;
    localparam logic [2:0] ERR_OUTSIDE = 3'd3;
    localparam logic [2:0] ERR_VOICE   = 3'd4;
    localparam logic [2:0] ERR_RANGE   = 3'd5;

    // Accidentals.
    localparam logic [1:0] ACC_NATURAL = 2'd0;
    localparam logic [1:0] ACC_SHARP   = 2'd1;
    localparam logic [1:0] ACC_FLAT    = 2'd2;

    // Length shifts applied to the whole note.
    localparam logic [2:0] LEN_WHOLE   = 3'd0;
    localparam logic [2:0] LEN_HALF    = 3'd1;
    localparam logic [2:0] LEN_QUARTER = 3'd2;
    localparam logic [2:0] LEN_EIGHTH  = 3'd3;
    localparam logic [2:0] LEN_16TH    = 3'd4;
    localparam logic [2:0] LEN_32ND    = 3'd5;

    localparam logic [3:0] OCTAVE_RESET = 4'd4;

    // Characters of the text.
    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CASE_OFFS  = 8'h20;
    localparam logic [7:0] CH_0       = 8'h30;
    localparam logic [7:0] CH_1       = 8'h31;
    localparam logic [7:0] CH_3       = 8'h33;
    localparam logic [7:0] CH_9       = 8'h39;
    localparam logic [7:0] CH_SHARP   = 8'h23;
    localparam logic [7:0] CH_FLAT    = 8'h24;
    localparam logic [7:0] CH_A       = 8'h61;
    localparam logic [7:0] CH_B       = 8'h62;
    localparam logic [7:0] CH_C       = 8'h63;
    localparam logic [7:0] CH_D       = 8'h64;
    localparam logic [7:0] CH_E       = 8'h65;
    localparam logic [7:0] CH_F       = 8'h66;
    localparam logic [7:0] CH_G       = 8'h67;
    localparam logic [7:0] CH_H       = 8'h68;
    localparam logic [7:0] CH_I       = 8'h69;
    localparam logic [7:0] CH_O       = 8'h6F;
    localparam logic [7:0] CH_Q       = 8'h71;
    localparam logic [7:0] CH_R       = 8'h72;
    localparam logic [7:0] CH_S       = 8'h73;
    localparam logic [7:0] CH_V       = 8'h76;
    localparam logic [7:0] CH_W       = 8'h77;

    // Lowest octave pitches in Hz with 16 fraction bits, one per semitone above A.
    function automatic logic [21:0] pitch_q16(input logic [3:0] semi);
        logic [21:0] t;
        case (semi)
            4'd0:    t = 22'd1802240;
            4'd1:    t = 22'd1909407;
            4'd2:    t = 22'd2022946;
            4'd3:    t = 22'd2143237;
            4'd4:    t = 22'd2270680;
            4'd5:    t = 22'd2405702;
            4'd6:    t = 22'd2548752;
            4'd7:    t = 22'd2700309;
            4'd8:    t = 22'd2860878;
            4'd9:    t = 22'd3030994;
            4'd10:   t = 22'd3211227;
            4'd11:   t = 22'd3402176;
            default: t = 22'd0;
        endcase
        return t;
    endfunction

endpackage

`default_nettype wire

// ----- src/cmtp_front.sv -----
`default_nettype none

module cmtp_front #(
    parameter int unsigned VOICE_COUNT = 9
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   char_valid,
    output logic                        char_ready,
    input  wire cmtp_pkg::cmtp_in_t     char_data,
    input  wire cmtp_pkg::cmtp_q_status_t q_status,
    output logic                        push,
    output cmtp_pkg::cmtp_cmd_t         push_cmd
);

    localparam logic [7:0] VoiceLast = 8'(32'(cmtp_pkg::CH_1) + VOICE_COUNT - 1);

    logic       expect_voice_reg, expect_voice_next;
    logic       expect_octave_reg, expect_octave_next;
    logic       in_voice_reg, in_voice_next;
    logic [3:0] active_voice_reg, active_voice_next;
    logic [3:0] octave_reg, octave_next;
    logic [1:0] accidental_reg, accidental_next;
    logic [2:0] len_reg, len_next;

    logic [7:0]  c;
    logic [7:0]  lc;
    logic [7:0]  c_from_1;
    logic [7:0]  c_from_0;
    logic        accept;

    // Pitch decode of the current letter.
    logic [3:0]  base_semi;
    logic        lower_octave;
    logic [3:0]  semi;
    logic [1:0]  oct_dec;
    logic        below_range;
    logic [3:0]  oct_eff;
    logic [31:0] freq_wide;

    assign char_ready = !q_status.full;
    assign accept     = char_valid && char_ready;
    assign c          = char_data.char_code;
    assign lc         = (c >= cmtp_pkg::CH_UPPER_A && c <= cmtp_pkg::CH_UPPER_Z)
                        ? c + cmtp_pkg::CASE_OFFS : c;
    assign c_from_1   = c - cmtp_pkg::CH_1;
    assign c_from_0   = c - cmtp_pkg::CH_0;

    // Semitone above A and octave adjust for each note letter.
    always_comb
    begin
        base_semi    = 4'd0;
        lower_octave = 1'b0;
        case (lc)
            cmtp_pkg::CH_B: base_semi = 4'd2;
            cmtp_pkg::CH_C: begin base_semi = 4'd3;  lower_octave = 1'b1; end
            cmtp_pkg::CH_D: begin base_semi = 4'd5;  lower_octave = 1'b1; end
            cmtp_pkg::CH_E: begin base_semi = 4'd7;  lower_octave = 1'b1; end
            cmtp_pkg::CH_F: begin base_semi = 4'd8;  lower_octave = 1'b1; end
            cmtp_pkg::CH_G: begin base_semi = 4'd10; lower_octave = 1'b1; end
            default:        base_semi = 4'd0;
        endcase
    end

    // Apply the accidental; a flat A wraps to G sharp one octave down.
    always_comb
    begin
        semi    = base_semi;
        oct_dec = {1'b0, lower_octave};
        if (accidental_reg == cmtp_pkg::ACC_SHARP)
        begin
            semi = base_semi + 4'd1;
        end
        else if (accidental_reg == cmtp_pkg::ACC_FLAT)
        begin
            if (base_semi == 4'd0)
            begin
                semi    = 4'd11;
                oct_dec = 2'({1'b0, lower_octave}) + 2'd1;
            end
            else
            begin
                semi = base_semi - 4'd1;
            end
        end
    end

    assign below_range = octave_reg < {2'b00, oct_dec};
    assign oct_eff     = octave_reg - {2'b00, oct_dec};
    assign freq_wide   = (32'(cmtp_pkg::pitch_q16(semi)) << oct_eff) + 32'd128;

    // Parser state update and command build.
    always_comb
    begin
        expect_voice_next  = expect_voice_reg;
        expect_octave_next = expect_octave_reg;
        in_voice_next      = in_voice_reg;
        active_voice_next  = active_voice_reg;
        octave_next        = octave_reg;
        accidental_next    = accidental_reg;
        len_next           = len_reg;

        push_cmd            = '0;
        push_cmd.clear      = char_data.block_start;
        push_cmd.voice      = active_voice_reg;
        push_cmd.len_shift  = len_reg;
        push_cmd.error_code = cmtp_pkg::ERR_NONE;

        if (expect_voice_reg)
        begin
            expect_voice_next = 1'b0;
            if (c >= cmtp_pkg::CH_1 && c <= VoiceLast)
            begin
                active_voice_next = c_from_1[3:0];
                in_voice_next     = 1'b1;
                octave_next       = cmtp_pkg::OCTAVE_RESET;
                accidental_next   = cmtp_pkg::ACC_NATURAL;
                len_next          = cmtp_pkg::LEN_WHOLE;
            end
            else
            begin
                in_voice_next       = 1'b0;
                push_cmd.emit       = 1'b1;
                push_cmd.error_code = cmtp_pkg::ERR_VOICE;
            end
        end
        else if (expect_octave_reg)
        begin
            expect_octave_next = 1'b0;
            if (c >= cmtp_pkg::CH_0 && c <= cmtp_pkg::CH_9)
            begin
                octave_next = c_from_0[3:0];
            end
            else
            begin
                if (lc == cmtp_pkg::CH_V)
                begin
                    expect_voice_next = 1'b1;
                end
                push_cmd.emit       = 1'b1;
                push_cmd.error_code = cmtp_pkg::ERR_OCTAVE;
            end
        end
        else if (lc == cmtp_pkg::CH_V)
        begin
            expect_voice_next = 1'b1;
        end
        else if (!in_voice_reg)
        begin
            push_cmd.emit       = 1'b1;
            push_cmd.error_code = cmtp_pkg::ERR_OUTSIDE;
        end
        else
        begin
            case (lc)
                cmtp_pkg::CH_O:     expect_octave_next = 1'b1;
                cmtp_pkg::CH_SHARP: accidental_next = cmtp_pkg::ACC_SHARP;
                cmtp_pkg::CH_FLAT:  accidental_next = cmtp_pkg::ACC_FLAT;
                cmtp_pkg::CH_3:     len_next = cmtp_pkg::LEN_32ND;
                cmtp_pkg::CH_S:     len_next = cmtp_pkg::LEN_16TH;
                cmtp_pkg::CH_I:     len_next = cmtp_pkg::LEN_EIGHTH;
                cmtp_pkg::CH_Q:     len_next = cmtp_pkg::LEN_QUARTER;
                cmtp_pkg::CH_H:     len_next = cmtp_pkg::LEN_HALF;
                cmtp_pkg::CH_W:     len_next = cmtp_pkg::LEN_WHOLE;
                cmtp_pkg::CH_A, cmtp_pkg::CH_B, cmtp_pkg::CH_C, cmtp_pkg::CH_D,
                cmtp_pkg::CH_E, cmtp_pkg::CH_F, cmtp_pkg::CH_G:
                begin
                    accidental_next = cmtp_pkg::ACC_NATURAL;
                    push_cmd.emit   = 1'b1;
                    if (below_range)
                    begin
                        push_cmd.error_code = cmtp_pkg::ERR_RANGE;
                    end
                    else
                    begin
                        push_cmd.freq = freq_wide[30:8];
                    end
                end
                cmtp_pkg::CH_R:
                begin
                    accidental_next = cmtp_pkg::ACC_NATURAL;
                    push_cmd.emit   = 1'b1;
                    push_cmd.rest   = 1'b1;
                end
                default:
                begin
                    push_cmd.emit       = 1'b1;
                    push_cmd.error_code = cmtp_pkg::ERR_UNKNOWN;
                end
            endcase
        end
    end

    // Only requests that clear the block or give a result reach the queue.
    assign push = accept && (push_cmd.emit || push_cmd.clear);

    // Parser state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_voice_reg  <= 1'b0;
            expect_octave_reg <= 1'b0;
            in_voice_reg      <= 1'b0;
            active_voice_reg  <= 4'd0;
            octave_reg        <= cmtp_pkg::OCTAVE_RESET;
            accidental_reg    <= cmtp_pkg::ACC_NATURAL;
            len_reg           <= cmtp_pkg::LEN_WHOLE;
        end
        else if (accept)
        begin
            expect_voice_reg  <= expect_voice_next;
            expect_octave_reg <= expect_octave_next;
            in_voice_reg      <= in_voice_next;
            active_voice_reg  <= active_voice_next;
            octave_reg        <= octave_next;
            accidental_reg    <= accidental_next;
            len_reg           <= len_next;
        end
    end

    // The parser never waits for a voice digit and an octave digit at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(expect_voice_reg && expect_octave_reg))
    else $error("front waits for voice and octave digit together");

    // A selected voice always has a time slot.
    assert property (@(posedge clk) disable iff (!rst_n)
        32'(active_voice_reg) < VOICE_COUNT)
    else $error("active voice out of range");

endmodule

`default_nettype wire

// ----- src/cmtp_queue.sv -----
`default_nettype none

module cmtp_queue (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                push,
    input  wire cmtp_pkg::cmtp_cmd_t push_cmd,
    input  wire logic                pop,
    output cmtp_pkg::cmtp_cmd_t      head_cmd,
    output cmtp_pkg::cmtp_q_status_t status
);

    cmtp_pkg::cmtp_cmd_t mem_reg [cmtp_pkg::QUEUE_DEPTH];

    logic [cmtp_pkg::QPTR_W-1:0] wr_ptr_reg;
    logic [cmtp_pkg::QPTR_W-1:0] rd_ptr_reg;
    logic [cmtp_pkg::QCNT_W-1:0] count_reg;
    logic [cmtp_pkg::QCNT_W-1:0] count_next;

    assign status.full  = count_reg == cmtp_pkg::QCNT_W'(cmtp_pkg::QUEUE_DEPTH);
    assign status.empty = count_reg == '0;
    assign head_cmd     = mem_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    // Command storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    // Pushes only into free space and pops only from held entries.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(push && status.full) && !(pop && status.empty))
    else $error("queue overrun or underrun");

    // Occupancy matches the pointer distance.
    assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg[cmtp_pkg::QPTR_W-1:0] == (wr_ptr_reg - rd_ptr_reg)))
    else $error("queue count out of step with pointers");

endmodule

`default_nettype wire

// ----- src/cmtp_back.sv -----
`default_nettype none

module cmtp_back #(
    parameter int unsigned VOICE_COUNT = 9,
    parameter int unsigned TIME_BITS   = 32
) (
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic [23:0]          whole_note_samples,
    input  wire cmtp_pkg::cmtp_cmd_t  head_cmd,
    input  wire cmtp_pkg::cmtp_q_status_t q_status,
    output logic                      pop,
    output logic                      note_valid,
    input  wire logic                 note_ready,
    output cmtp_pkg::cmtp_out_t       note_data
);

    localparam int unsigned VoiceIdxW = (VOICE_COUNT > 1) ? $clog2(VOICE_COUNT) : 1;
    localparam int unsigned SumW      = ((TIME_BITS > 24) ? TIME_BITS : 24) + 1;
    localparam int unsigned CapW      = (TIME_BITS > 32) ? TIME_BITS : 32;
    localparam logic [TIME_BITS-1:0] TimeMax = {TIME_BITS{1'b1}};

    logic [TIME_BITS-1:0] voice_time_reg  [VOICE_COUNT];
    logic [TIME_BITS-1:0] voice_time_next [VOICE_COUNT];
    logic [TIME_BITS-1:0] longest_reg, longest_next;

    cmtp_pkg::cmtp_out_t out_reg, out_next;
    logic                out_valid_reg;

    logic [VoiceIdxW-1:0] vidx;
    logic                 is_note;
    logic                 out_free;
    logic [TIME_BITS-1:0] start;
    logic [TIME_BITS-1:0] base_longest;
    logic [23:0]          dur;
    logic [SumW-1:0]      sum;
    logic [TIME_BITS-1:0] stop_time;
    logic [TIME_BITS-1:0] new_longest;

    // Caps a time value to the 32-bit report width.
    function automatic logic [31:0] cap32(input logic [TIME_BITS-1:0] t);
        logic [CapW-1:0] ext;
        ext = CapW'(t);
        return (ext > CapW'(32'hFFFF_FFFF)) ? 32'hFFFF_FFFF : ext[31:0];
    endfunction

    assign out_free   = !out_valid_reg || note_ready;
    assign pop        = !q_status.empty && out_free;
    assign note_valid = out_valid_reg;
    assign note_data  = out_reg;

    assign vidx    = head_cmd.voice[VoiceIdxW-1:0];
    assign is_note = head_cmd.emit && (head_cmd.error_code == cmtp_pkg::ERR_NONE);

    // Time advance with saturation; a block start sees cleared times.
    assign start        = head_cmd.clear ? '0 : voice_time_reg[vidx];
    assign base_longest = head_cmd.clear ? '0 : longest_reg;
    assign dur          = whole_note_samples >> head_cmd.len_shift;
    assign sum          = SumW'(start) + SumW'(dur);
    assign stop_time    = (sum > SumW'(TimeMax)) ? TimeMax : sum[TIME_BITS-1:0];
    assign new_longest  = (stop_time > base_longest) ? stop_time : base_longest;

    // Next voice times and block length.
    always_comb
    begin
        for (int i = 0; i < VOICE_COUNT; i++)
        begin
            voice_time_next[i] = head_cmd.clear ? '0 : voice_time_reg[i];
        end
        longest_next = base_longest;
        if (is_note)
        begin
            voice_time_next[vidx] = stop_time;
            longest_next          = new_longest;
        end
    end

    // Result fields; an error carries only voice, error code and block length.
    always_comb
    begin
        out_next              = '0;
        out_next.voice        = head_cmd.voice;
        out_next.error_code   = head_cmd.error_code;
        out_next.block_length = cap32(base_longest);
        if (is_note)
        begin
            out_next.start_time   = cap32(start);
            out_next.duration     = dur;
            out_next.frequency_q8 = head_cmd.freq;
            out_next.is_rest      = head_cmd.rest;
            out_next.block_length = cap32(new_longest);
        end
    end

    // Voice time state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                voice_time_reg[i] <= '0;
            end
            longest_reg <= '0;
        end
        else if (pop)
        begin
            for (int i = 0; i < VOICE_COUNT; i++)
            begin
                voice_time_reg[i] <= voice_time_next[i];
            end
            longest_reg <= longest_next;
        end
    end

    // Output register.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= pop && head_cmd.emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && head_cmd.emit)
        begin
            out_reg <= out_next;
        end
    end

    // An error result never carries timing or pitch.
    assert property (@(posedge clk) disable iff (!rst_n)
        (note_valid && note_data.error_code != cmtp_pkg::ERR_NONE) |->
        (note_data.duration == '0 && note_data.frequency_q8 == '0 &&
         note_data.start_time == '0 && !note_data.is_rest))
    else $error("error result carries note fields");

endmodule

`default_nettype wire

// ----- src/compact_music_text_parser_core.sv -----
`default_nettype none

// Compact music text parser. One ASCII character is taken per request on the
// char channel; note letters and rests give one result on the note channel,
// setting characters give none, and errors give a flagged result. The block
// takes one character every cycle while the queue is not full: the front
// decodes a character and its pitch combinationally, a four-entry command
// queue follows, and the back end advances the per-voice time accumulators
// and loads the result register once per cycle while a command is queued
// and the result register is free. A stalled note channel first fills the
// queue and then holds char_ready low. The whole note length must be written
// on the cfg channel while the block is idle; the block does not enforce this.
module compact_music_text_parser_core #(
    parameter int unsigned VOICE_COUNT = 9,
    parameter int unsigned TIME_BITS   = 32
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                char_valid,
    output logic                     char_ready,
    input  wire cmtp_pkg::cmtp_in_t  char_data,
    output logic                     note_valid,
    input  wire logic                note_ready,
    output cmtp_pkg::cmtp_out_t      note_data,
    input  wire logic                cfg_valid,
    output logic                     cfg_ready,
    input  wire logic [23:0]         cfg_data
);

    logic [23:0]              whole_reg;
    logic                     push;
    logic                     pop;
    cmtp_pkg::cmtp_cmd_t      push_cmd;
    cmtp_pkg::cmtp_cmd_t      head_cmd;
    cmtp_pkg::cmtp_q_status_t q_status;

    // Whole note length register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            whole_reg <= cmtp_pkg::WHOLE_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            whole_reg <= cfg_data;
        end
    end

    cmtp_front #(
        .VOICE_COUNT (VOICE_COUNT)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_valid (char_valid),
        .char_ready (char_ready),
        .char_data  (char_data),
        .q_status   (q_status),
        .push       (push),
        .push_cmd   (push_cmd)
    );

    cmtp_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head_cmd (head_cmd),
        .status   (q_status)
    );

    cmtp_back #(
        .VOICE_COUNT (VOICE_COUNT),
        .TIME_BITS   (TIME_BITS)
    ) u_back (
        .clk                (clk),
        .rst_n              (rst_n),
        .whole_note_samples (whole_reg),
        .head_cmd           (head_cmd),
        .q_status           (q_status),
        .pop                (pop),
        .note_valid         (note_valid),
        .note_ready         (note_ready),
        .note_data          (note_data)
    );

endmodule

`default_nettype wire
